FILE: rtl/t2r_pkg.sv
package t2r_pkg;

   localparam int PALETTE_ENTRIES_DEFAULT = 256;
   localparam int PAL_INDEX_W             = 8;
   localparam int WORD_W                  = 32;
   localparam int FMT_W                   = 3;

   localparam logic [FMT_W-1:0] FMT_BGRA    = 3'd0;
   localparam logic [FMT_W-1:0] FMT_RGBA    = 3'd1;
   localparam logic [FMT_W-1:0] FMT_ABGR    = 3'd2;
   localparam logic [FMT_W-1:0] FMT_ARGB    = 3'd3;
   localparam logic [FMT_W-1:0] FMT_BGR     = 3'd4;
   localparam logic [FMT_W-1:0] FMT_RGB     = 3'd5;
   localparam logic [FMT_W-1:0] FMT_RGB565  = 3'd6;
   localparam logic [FMT_W-1:0] FMT_PALETTE = 3'd7;

   localparam logic [FMT_W-1:0] FMT_RESET = FMT_RGBA;

   localparam logic OP_PAL_WRITE = 1'b0;
   localparam logic OP_CONVERT   = 1'b1;

   typedef struct packed {
      logic                   wr_en;
      logic [PAL_INDEX_W-1:0] wr_addr;
      logic [WORD_W-1:0]      wr_data;
      logic                   rd_en;
      logic [PAL_INDEX_W-1:0] rd_addr;
   } t2r_pal_req_type;

endpackage

FILE: rtl/t2r_palette.sv
module t2r_palette
   import t2r_pkg::*;
#(
   parameter int ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
   input  logic              clock,
   input  t2r_pal_req_type   pal_req,
   output logic [WORD_W-1:0] rd_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [WORD_W-1:0] mem [ENTRIES];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (pal_req.wr_en) begin
         mem[pal_req.wr_addr[IDX_W-1:0]] <= pal_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (pal_req.rd_en) begin
         rd_data_ff <= mem[pal_req.rd_addr[IDX_W-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/t2r_unpack.sv
module t2r_unpack
   import t2r_pkg::*;
(
   input  logic [FMT_W-1:0]  fmt,
   input  logic [WORD_W-1:0] texel,
   output logic [WORD_W-1:0] word
);

   // floor(v*255/31) = 8v + floor(7v/31)
   function automatic logic [7:0] expand5(input logic [4:0] v);
      logic [2:0] corr;
      begin
         if (v >= 5'd31)      corr = 3'd7;
         else if (v >= 5'd27) corr = 3'd6;
         else if (v >= 5'd23) corr = 3'd5;
         else if (v >= 5'd18) corr = 3'd4;
         else if (v >= 5'd14) corr = 3'd3;
         else if (v >= 5'd9)  corr = 3'd2;
         else if (v >= 5'd5)  corr = 3'd1;
         else                 corr = 3'd0;
         expand5 = {v, 3'b000} + {5'b00000, corr};
      end
   endfunction

   // floor(v*255/63) = 4v + floor(v/21)
   function automatic logic [7:0] expand6(input logic [5:0] v);
      logic [1:0] corr;
      begin
         if (v >= 6'd63)      corr = 2'd3;
         else if (v >= 6'd42) corr = 2'd2;
         else if (v >= 6'd21) corr = 2'd1;
         else                 corr = 2'd0;
         expand6 = {v, 2'b00} + {6'b000000, corr};
      end
   endfunction

   logic [7:0]  b0, b1, b2, b3;
   logic [15:0] w565;

   assign b0   = texel[7:0];
   assign b1   = texel[15:8];
   assign b2   = texel[23:16];
   assign b3   = texel[31:24];
   assign w565 = {b1, b0};

   // packed as {A, B, G, R}
   always_comb begin
      unique case (fmt)
         FMT_BGRA:   word = {b3, b0, b1, b2};
         FMT_RGBA:   word = {b3, b2, b1, b0};
         FMT_ABGR:   word = {b0, b1, b2, b3};
         FMT_ARGB:   word = {b0, b3, b2, b1};
         FMT_BGR:    word = {8'h00, b0, b1, b2};
         FMT_RGB:    word = {8'h00, b2, b1, b0};
         FMT_RGB565: word = {8'hff, expand5(w565[4:0]), expand6(w565[10:5]),
                             expand5(w565[15:11])};
         default:    word = '0;   // palette handled downstream
      endcase
   end

endmodule

FILE: rtl/texel_to_rgba8_converter_unit.sv
// Channel   Ports                                     Beat
// -------   ---------------------------------------   ---------------------------
// req       req_valid/req_ready, op, texel, palette   one texel or palette write
// rsp       rsp_valid/rsp_ready, rsp_rgba_word         one RGBA8888 word
// csr       csr_wr_en/csr_wr_data                      source format, no wait
//
// One beat is taken every cycle unless a held rsp beat freezes all three stages;
// a convert beat goes through stage one, stage two and the rsp register. Palette
// writes land in the palette RAM on the cycle they are taken and give no rsp
// beat. The palette RAM read port is registered as stage one. Reset clears the
// stage valid bits and sets the format to RGBA; palette contents are not cleared.
module texel_to_rgba8_converter_unit
   import t2r_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic [WORD_W-1:0]      req_texel_bytes,
   input  logic [PAL_INDEX_W-1:0] req_palette_index,
   input  logic [WORD_W-1:0]      req_palette_color,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [WORD_W-1:0]      rsp_rgba_word,

   input  logic                   csr_wr_en,
   input  logic [FMT_W-1:0]       csr_wr_data
);

   localparam logic [PAL_INDEX_W:0] ENTRY_LIMIT = (PAL_INDEX_W+1)'(PALETTE_ENTRIES);

   logic [FMT_W-1:0] fmt_ff;

   logic advance;
   logic accept;

   logic              s1_valid_ff, s1_valid_in;
   logic [WORD_W-1:0] s1_texel_ff;
   logic              s1_hit_ff;

   logic              s2_valid_ff;
   logic [WORD_W-1:0] s2_word_ff, s2_word_in;
   logic [WORD_W-1:0] s2_entry_ff;
   logic              s2_hit_ff;

   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;

   t2r_pal_req_type   pal_req;
   logic [WORD_W-1:0] pal_rd_data;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_RESET;
      end else if (csr_wr_en) begin
         fmt_ff <= csr_wr_data;
      end
   end

   always_comb begin
      pal_req.wr_en   = accept && (req_op == OP_PAL_WRITE) &&
                        ({1'b0, req_palette_index} < ENTRY_LIMIT);
      pal_req.wr_addr = req_palette_index;
      pal_req.wr_data = req_palette_color;
      pal_req.rd_en   = accept && (req_op == OP_CONVERT);
      pal_req.rd_addr = req_texel_bytes[PAL_INDEX_W-1:0];
   end

   t2r_palette #(
      .ENTRIES (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .pal_req (pal_req),
      .rd_data (pal_rd_data)
   );

   // stage 1: capture beat, palette read in flight
   assign s1_valid_in = accept && (req_op == OP_CONVERT);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         s1_texel_ff <= req_texel_bytes;
         s1_hit_ff   <= {1'b0, req_texel_bytes[PAL_INDEX_W-1:0]} < ENTRY_LIMIT;
      end
   end

   // stage 2: byte swizzle and 565 expansion
   t2r_unpack u_unpack (
      .fmt   (fmt_ff),
      .texel (s1_texel_ff),
      .word  (s2_word_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         s2_word_ff  <= s2_word_in;
         s2_entry_ff <= pal_rd_data;
         s2_hit_ff   <= s1_hit_ff;
      end
   end

   // stage 3: palette BGRA to RGBA, final select
   always_comb begin
      if (fmt_ff == FMT_PALETTE) begin
         rsp_word_in = s2_hit_ff ? {s2_entry_ff[31:24], s2_entry_ff[7:0],
                                    s2_entry_ff[15:8], s2_entry_ff[23:16]} : '0;
      end else begin
         rsp_word_in = s2_word_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s2_valid_ff) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rgba_word = rsp_word_ff;

endmodule

FILE: rtl/t2r_checker.sv
module t2r_checker
   import t2r_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [WORD_W-1:0]      rsp_rgba_word
);

   // held rsp beat keeps its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rgba_word))
      else $error("rsp beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // pipeline freezes as a whole on an rsp stall
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req taken while rsp stalled");

   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req refused with empty output");

   // handshake lines stay defined once out of reset
   a_handshake_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_valid, req_ready, rsp_valid, rsp_ready}))
      else $error("handshake line unknown");

endmodule

bind texel_to_rgba8_converter_unit t2r_checker u_t2r_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_rgba_word (rsp_rgba_word)
);

FILE: tb/texel_to_rgba8_converter_unit_test.sv
`timescale 1ns / 1ps

module texel_to_rgba8_converter_unit_test
   import t2r_pkg::*;
;

   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned PHASE_BEATS  = 70;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_op;
   logic [WORD_W-1:0]      req_texel_bytes;
   logic [PAL_INDEX_W-1:0] req_palette_index;
   logic [WORD_W-1:0]      req_palette_color;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [WORD_W-1:0]      rsp_rgba_word;
   logic                   csr_wr_en;
   logic [FMT_W-1:0]       csr_wr_data;

   texel_to_rgba8_converter_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_texel_bytes   (req_texel_bytes),
      .req_palette_index (req_palette_index),
      .req_palette_color (req_palette_color),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_rgba_word     (rsp_rgba_word),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   class rgba_scoreboard;
      logic [FMT_W-1:0]  source_format;
      logic [WORD_W-1:0] palette_copy [PALETTE_ENTRIES_DEFAULT];
      logic [WORD_W-1:0] pending_words [$];
      int unsigned       mismatches;

      function new();
         source_format = FMT_RESET;
         mismatches    = 0;
         foreach (palette_copy[i]) palette_copy[i] = '0;
      endfunction

      function logic [WORD_W-1:0] rgba_of(input logic [WORD_W-1:0] t);
         logic [7:0]        b0, b1, b2, b3;
         logic [7:0]        rr, gg, bb;
         logic [15:0]       w;
         int unsigned       lo, mid, hi;
         logic [WORD_W-1:0] e;
         b0 = t[7:0];
         b1 = t[15:8];
         b2 = t[23:16];
         b3 = t[31:24];
         case (source_format)
            FMT_BGRA: return {b3, b0, b1, b2};
            FMT_RGBA: return {b3, b2, b1, b0};
            FMT_ABGR: return {b0, b1, b2, b3};
            FMT_ARGB: return {b0, b3, b2, b1};
            FMT_BGR:  return {8'h00, b0, b1, b2};
            FMT_RGB:  return {8'h00, b2, b1, b0};
            FMT_RGB565: begin
               w   = {b1, b0};
               lo  = 32'(w[4:0]);
               mid = 32'(w[10:5]);
               hi  = 32'(w[15:11]);
               rr  = 8'((hi * 255) / 31);
               gg  = 8'((mid * 255) / 63);
               bb  = 8'((lo * 255) / 31);
               return {8'hff, bb, gg, rr};
            end
            default: begin
               if (int'(b0) >= PALETTE_ENTRIES_DEFAULT) return '0;
               e = palette_copy[b0];
               return {e[31:24], e[7:0], e[15:8], e[23:16]};
            end
         endcase
      endfunction

      function void note_beat(input logic op, input logic [WORD_W-1:0] texel,
                              input logic [PAL_INDEX_W-1:0] idx,
                              input logic [WORD_W-1:0] color);
         if (op == OP_PAL_WRITE) begin
            if (int'(idx) < PALETTE_ENTRIES_DEFAULT) palette_copy[idx] = color;
         end else begin
            pending_words.push_back(rgba_of(texel));
         end
      endfunction

      function void check_word(input logic [WORD_W-1:0] actual);
         logic [WORD_W-1:0] want;
         if (pending_words.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected rgba beat, expected none, actual %08h", $time, actual);
         end else begin
            want = pending_words.pop_front();
            if (actual !== want) begin
               mismatches++;
               $display("%0t: rgba_word mismatch, expected %08h, actual %08h",
                        $time, want, actual);
            end
         end
      endfunction
   endclass

   rgba_scoreboard         sb;
   bit                     written [PALETTE_ENTRIES_DEFAULT];
   logic [PAL_INDEX_W-1:0] filled_slots [$];
   bit                     steady_phase;
   int unsigned            stall_cycles;

   logic [FMT_W-1:0] format_plan [12] = '{FMT_BGRA, FMT_RGBA, FMT_ABGR, FMT_ARGB, FMT_BGR,
                                          FMT_RGB, FMT_RGB565, FMT_PALETTE, FMT_PALETTE,
                                          FMT_BGRA, FMT_RGB565, FMT_ARGB};

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly short gaps, the odd long one; none at all in a steady phase
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady_phase) return 0;
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_beat(input logic op, input logic [WORD_W-1:0] texel,
                            input logic [PAL_INDEX_W-1:0] idx,
                            input logic [WORD_W-1:0] color);
      int unsigned gap;
      @(negedge clock);
      req_valid         <= 1'b1;
      req_op            <= op;
      req_texel_bytes   <= texel;
      req_palette_index <= idx;
      req_palette_color <= color;
      do @(posedge clock); while (!req_ready);
      sb.note_beat(op, texel, idx, color);
      if (op == OP_PAL_WRITE && !written[idx]) begin
         written[idx] = 1'b1;
         filled_slots.push_back(idx);
      end
      gap = pick_gap();
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic random_beat();
      logic                   op;
      logic [WORD_W-1:0]      texel, color;
      logic [PAL_INDEX_W-1:0] idx;
      int unsigned            wr_pct;
      wr_pct = (sb.source_format == FMT_PALETTE) ? 30 : 15;
      op     = ($urandom_range(0, 99) < wr_pct) ? OP_PAL_WRITE : OP_CONVERT;
      texel  = $urandom;
      idx    = PAL_INDEX_W'($urandom_range(0, 255));
      color  = $urandom;
      case ($urandom_range(0, 9))
         0: texel = '0;
         1: texel = '1;
         2: color = '0;
         3: color = '1;
         default: ;
      endcase
      // lookups only ever hit entries already written
      if (op == OP_CONVERT && sb.source_format == FMT_PALETTE)
         texel[7:0] = filled_slots[$urandom_range(0, filled_slots.size() - 1)];
      send_beat(op, texel, idx, color);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_format(input logic [FMT_W-1:0] fmt);
      drain();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= fmt;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.source_format = fmt;
   endtask

   // result side: random back-pressure
   initial begin
      int unsigned n;
      rsp_ready = 1'b0;
      forever begin
         n = pick_gap();
         repeat (n) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         n = steady_phase ? 1 : $urandom_range(1, 12);
         repeat (n) begin
            @(negedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) sb.check_word(rsp_rgba_word);
      end
   end

   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      sb                = new();
      steady_phase      = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_op            = OP_CONVERT;
      req_texel_bytes   = '0;
      req_palette_index = '0;
      req_palette_color = '0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = FMT_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset format, byte extremes, palette extremes
      send_beat(OP_CONVERT, 32'h0000_0000, 8'h00, 32'h0000_0000);
      send_beat(OP_CONVERT, 32'hffff_ffff, 8'hff, 32'hffff_ffff);
      send_beat(OP_CONVERT, 32'h0403_0201, 8'h00, 32'h0000_0000);
      send_beat(OP_CONVERT, 32'h8040_2010, 8'h00, 32'h0000_0000);
      send_beat(OP_PAL_WRITE, 32'h0000_0000, 8'h00, 32'hffff_ffff);
      send_beat(OP_PAL_WRITE, 32'hffff_ffff, 8'hff, 32'h0000_0000);
      send_beat(OP_PAL_WRITE, 32'h0000_0000, 8'h55, 32'ha5c3_e10f);
      send_beat(OP_PAL_WRITE, 32'h0000_0000, 8'haa, 32'h5a3c_1ef0);

      set_format(FMT_RGB565);
      send_beat(OP_CONVERT, 32'h0000_0000, 8'h00, 32'h0000_0000);
      send_beat(OP_CONVERT, 32'hffff_ffff, 8'h00, 32'h0000_0000);
      send_beat(OP_CONVERT, 32'h0000_001f, 8'h00, 32'h0000_0000);
      send_beat(OP_CONVERT, 32'h0000_07e0, 8'h00, 32'h0000_0000);
      send_beat(OP_CONVERT, 32'h0000_f800, 8'h00, 32'h0000_0000);
      send_beat(OP_CONVERT, 32'hffff_0000, 8'h00, 32'h0000_0000);

      // unused upper bytes must not affect the lookup
      set_format(FMT_PALETTE);
      send_beat(OP_CONVERT, 32'h0000_0000, 8'h00, 32'h0000_0000);
      send_beat(OP_CONVERT, 32'hffff_ff00, 8'h00, 32'h0000_0000);
      send_beat(OP_CONVERT, 32'h0000_00ff, 8'h00, 32'h0000_0000);
      send_beat(OP_CONVERT, 32'h1234_5655, 8'h00, 32'h0000_0000);
      send_beat(OP_CONVERT, 32'h0000_00aa, 8'h00, 32'h0000_0000);
      // write then read the same entry on the next beat
      steady_phase = 1'b1;
      send_beat(OP_PAL_WRITE, 32'h0000_0000, 8'h00, 32'h1122_3344);
      send_beat(OP_CONVERT, 32'h0000_0000, 8'h00, 32'h0000_0000);
      steady_phase = 1'b0;

      set_format(FMT_BGR);
      send_beat(OP_CONVERT, 32'hffff_ffff, 8'h00, 32'h0000_0000);

      foreach (format_plan[p]) begin
         set_format(format_plan[p]);
         steady_phase = ($urandom_range(0, 3) == 0);
         repeat (PHASE_BEATS) random_beat();
      end

      steady_phase = 1'b0;
      drain();
      if (sb.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
